/* rtl/core/sbd_pkg.sv */
// Shared types, constants and tables for the spectrum bar display block.
package sbd_pkg;

  localparam int NumBands = 5;
  localparam int DivW     = 21;
  localparam int LvlW     = 14;
  localparam int SumW     = 18;
  localparam int VolW     = 10;
  localparam int RecipW   = 22;
  localparam int RecipSh  = 22;

  localparam logic [LvlW-1:0] LevelMax  = 14'd16383;
  localparam logic [LvlW-1:0] SpanMax   = 14'd10000;
  localparam logic [13:0]     BinClamp  = 14'd10000;
  localparam logic [SumW-1:0] SumMax    = 18'h3FFFF;
  localparam logic [VolW-1:0] VolumeMax = 10'd1000;
  localparam logic [4:0]      VbarScale = 5'd20;
  localparam logic [5:0]      VbarMax   = 6'd38;
  localparam logic [2:0]      BandNone  = 3'd5;

  localparam logic [7:0] NOISE_TAB [0:63] = '{
    8'd0,   8'd152, 8'd93, 8'd106, 8'd69, 8'd64, 8'd82, 8'd58,
    8'd48,  8'd71,  8'd44, 8'd42,  8'd56, 8'd40, 8'd33, 8'd47,
    8'd32,  8'd29,  8'd37, 8'd30,  8'd22, 8'd32, 8'd24, 8'd22,
    8'd25,  8'd24,  8'd19, 8'd24,  8'd20, 8'd20, 8'd20, 8'd21,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [13:0] BAND_DIV [0:NumBands-1] = '{14'd5, 14'd4, 14'd6, 14'd2, 14'd15};

  // ceil(2^22 / divisor): exact floor quotient for any 18-bit band sum
  localparam logic [RecipW-1:0] BAND_RECIP [0:NumBands-1] = '{
    22'd838861, 22'd1048576, 22'd699051, 22'd2097152, 22'd279621
  };

  typedef enum logic [1:0] {
    REG_VOL_NOISE = 2'd0,
    REG_MIN_SPAN  = 2'd1,
    REG_DECAY     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [VolW-1:0] vol_noise;
    logic [13:0]     min_span;
    logic [7:0]      decay;
  } cfg_t;

  typedef struct packed {
    logic [NumBands-1:0][SumW-1:0] sums;
    logic [11:0]                   raw_vol;
    logic                          store;
  } frame_t;

  typedef struct packed {
    logic [LvlW-1:0] vmin;
    logic [LvlW-1:0] vmax;
    logic [VolW-1:0] vol;
  } hist_t;

  typedef enum logic [4:0] {
    B_IDLE, B_LVL, B_HIST_RD, B_HIST_UPD, B_AVG,
    B_SPAN, B_DEC, B_HT_ST, B_HT_WT, B_SCAN_INIT, B_SCAN, B_VDEC,
    B_VBAR_ST, B_VBAR_WT, B_OUT
  } back_state_e;

  function automatic logic [2:0] band_of_bin(logic [5:0] b);
    logic [2:0] r;
    if (b == 6'd0) r = BandNone;
    else if (b <= 6'd3) r = 3'd0;
    else if (b <= 6'd6) r = 3'd1;
    else if (b <= 6'd9) r = 3'd2;
    else if (b <= 6'd12) r = 3'd3;
    else r = 3'd4;
    return r;
  endfunction

  function automatic logic [LvlW-1:0] decayed(logic [LvlW-1:0] held, logic [7:0] k);
    logic [LvlW+7:0] p;
    p = held * k;
    return p[LvlW+7:8];
  endfunction

endpackage

/* rtl/core/spectrum_bar_display_agc.sv */
// Spectrum bar display with automatic gain: top level.
// Bins are taken one per cycle while the two-frame queue has room; only the
// last bin of a frame yields a result word. The frame processor then works
// through a frame in steps: the band levels (reciprocal multiplies), the
// history update of a stored frame, the averages, the span, per band the
// decay plus, where needed, a serial divide over the 21 quotient bits for
// the height, a volume history scan, the volume decay, the volume bar
// divide, and loading the output register. The serial divider and the
// single history RAM read port set how long a frame takes. The result waits
// in an output register until popped while the next frame is already being
// processed. The write slot and a wrap flag track which history entries hold
// data, so unwritten entries count as zero and no clearing pass runs after
// reset.
module spectrum_bar_display_agc import sbd_pkg::*; #(
  parameter int NUM_BINS       = 32,
  parameter int HISTORY_FRAMES = 100,
  parameter int BAR_HEIGHT     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] bin_magnitude_i,
  input  logic [11:0] raw_volume_i,
  input  logic        store_frame_i,
  input  logic        last_bin_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  height_col0_o,
  output logic [3:0]  height_col1_o,
  output logic [3:0]  height_col2_o,
  output logic [3:0]  height_col3_o,
  output logic [3:0]  height_col4_o,
  output logic [5:0]  volume_bar_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i
);
  cfg_t   cfg_q;
  logic   take, frame_push, fifo_full, fifo_empty, fifo_pop;
  frame_t frame_in, frame_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vol_noise <= 10'd25;
      cfg_q.min_span  <= 14'd300;
      cfg_q.decay     <= 8'd238;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VOL_NOISE: cfg_q.vol_noise <= cfg_data_i[VolW-1:0];
        REG_MIN_SPAN:  cfg_q.min_span  <= cfg_data_i;
        REG_DECAY:     cfg_q.decay     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign full = fifo_full;
  assign take = push && !fifo_full;

  sbd_front #(.NUM_BINS(NUM_BINS)) u_front (
    .clk_i, .rst_ni,
    .take_i          (take),
    .bin_magnitude_i,
    .raw_volume_i,
    .store_frame_i,
    .last_bin_i,
    .frame_push_o    (frame_push),
    .frame_o         (frame_in)
  );

  sbd_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i  (frame_push),
    .wdata_i (frame_in),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .rdata_o (frame_out)
  );

  sbd_back #(.HISTORY_FRAMES(HISTORY_FRAMES), .BAR_HEIGHT(BAR_HEIGHT)) u_back (
    .clk_i, .rst_ni,
    .cfg_i         (cfg_q),
    .fifo_empty_i  (fifo_empty),
    .frame_i       (frame_out),
    .fifo_pop_o    (fifo_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .height_col0_o,
    .height_col1_o,
    .height_col2_o,
    .height_col3_o,
    .height_col4_o,
    .volume_bar_o
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> volume_bar_o <= 6'd38)
    else $error("volume bar out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (height_col0_o <= 5'(BAR_HEIGHT + 1) && height_col4_o <= 5'(BAR_HEIGHT + 1)))
    else $error("bar height out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("frame queue read while empty");
endmodule

/* rtl/core/sbd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrW-1:0]      waddr_i,
  input  logic [Width-1:0]      wdata_i,
  input  logic [AddrW-1:0]      raddr_i,
  output logic [Width-1:0]      rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/core/sbd_div.sv */
// Restoring divider, one quotient bit per cycle.
module sbd_div import sbd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] num_i,
  input  logic [13:0]     den_i,
  output logic            busy_o,
  output logic [DivW-1:0] quo_o
);
  logic [DivW-1:0] quo_q, quo_d;
  logic [13:0]     rem_q, rem_d, den_q;
  logic [4:0]      cnt_q;
  logic            busy_q;
  logic [14:0]     trial;
  logic            ge;

  always_comb begin
    trial = {rem_q, quo_q[DivW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? 14'(trial - {1'b0, den_q}) : trial[13:0];
    quo_d = {quo_q[DivW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'(DivW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
endmodule

/* rtl/core/sbd_fifo.sv */
// Two-entry frame queue between the bin accumulator and the frame processor.
module sbd_fifo import sbd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t wdata_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output frame_t rdata_o
);
  frame_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];
endmodule

/* rtl/core/sbd_front.sv */
// Bin accumulator: noise floor removal, clamping and band summing.
module sbd_front import sbd_pkg::*; #(
  parameter int NUM_BINS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [15:0] bin_magnitude_i,
  input  logic [11:0] raw_volume_i,
  input  logic        store_frame_i,
  input  logic        last_bin_i,
  output logic        frame_push_o,
  output frame_t      frame_o
);
  localparam int PosW = $clog2(NUM_BINS);

  logic [PosW-1:0]               pos_q;
  logic [NumBands-1:0][SumW-1:0] sums_q, sums_d;
  logic [7:0]                    nf;
  logic [15:0]                   val_raw;
  logic [13:0]                   val;
  logic [2:0]                    band;
  logic [SumW:0]                 acc;

  always_comb begin
    nf      = NOISE_TAB[6'(pos_q)];
    val_raw = (bin_magnitude_i > 16'(nf)) ? bin_magnitude_i - 16'(nf) : 16'd0;
    val     = (val_raw > 16'(BinClamp)) ? BinClamp : val_raw[13:0];
    band    = band_of_bin(6'(pos_q));
    sums_d  = sums_q;
    acc     = '0;
    for (int i = 0; i < NumBands; i++) begin
      if (band == 3'(i)) begin
        acc       = {1'b0, sums_q[i]} + (SumW+1)'(val);
        sums_d[i] = (acc > {1'b0, SumMax}) ? SumMax : acc[SumW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sums_q <= '0;
    end else if (take_i) begin
      if (last_bin_i) begin
        pos_q  <= '0;
        sums_q <= '0;
      end else begin
        sums_q <= sums_d;
        if (pos_q != PosW'(NUM_BINS - 1)) pos_q <= pos_q + 1'b1;
      end
    end
  end

  assign frame_push_o    = take_i && last_bin_i;
  assign frame_o.sums    = sums_d;
  assign frame_o.raw_vol = raw_volume_i;
  assign frame_o.store   = store_frame_i;
endmodule

/* rtl/core/sbd_back.sv */
// Frame processor: levels, history, gain span, decay, bar heights and volume bar.
module sbd_back import sbd_pkg::*; #(
  parameter int HISTORY_FRAMES = 100,
  parameter int BAR_HEIGHT     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        fifo_empty_i,
  input  frame_t      frame_i,
  output logic        fifo_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [3:0]  height_col0_o,
  output logic [3:0]  height_col1_o,
  output logic [3:0]  height_col2_o,
  output logic [3:0]  height_col3_o,
  output logic [3:0]  height_col4_o,
  output logic [5:0]  volume_bar_o
);
  localparam int HW = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
  localparam logic [4:0] HtMax = 5'(BAR_HEIGHT + 1);
  localparam logic [3:0] Bh    = 4'(BAR_HEIGHT);
  // ceil(2^28 / HISTORY_FRAMES): exact floor quotient for any 21-bit history sum
  localparam int AvgSh = 28;
  localparam logic [AvgSh:0] AvgRecip =
    (AvgSh+1)'(((64'd1 << AvgSh) + 64'(HISTORY_FRAMES) - 64'd1) / 64'(HISTORY_FRAMES));

  back_state_e state_q, state_d;

  frame_t              frm_q, frm_d;
  logic [2:0]          idx_q, idx_d;
  logic [LvlW-1:0]     lvl_q [NumBands];
  logic [LvlW-1:0]     lvl_d [NumBands];
  logic [LvlW-1:0]     held_q [NumBands];
  logic [LvlW-1:0]     held_d [NumBands];
  logic [3:0]          ht_q [NumBands];
  logic [3:0]          ht_d [NumBands];
  logic [LvlW-1:0]     fmin_q, fmin_d, fmax_q, fmax_d;
  logic [VolW-1:0]     vol_q, vol_d, hvol_q, hvol_d;
  logic [HW-1:0]       slot_q, slot_d;
  logic                wrap_q, wrap_d;
  logic [DivW-1:0]     smin_q, smin_d, smax_q, smax_d;
  logic [LvlW-1:0]     amin_q, amin_d, amax_q, amax_d, span_q, span_d;
  logic [VolW-1:0]     vmin_q, vmin_d, vmax_q, vmax_d;
  logic [HW:0]         scan_q, scan_d, cnt;
  logic                rdv_q, rdv_d;
  logic [5:0]          vbar_q, vbar_d;
  logic                ovld_q, ovld_d;
  logic [3:0]          oht_q [NumBands];
  logic [5:0]          ovbar_q;

  logic                div_start, div_busy;
  logic [DivW-1:0]     div_num, div_quo;
  logic [13:0]         div_den;
  logic                ram_we;
  logic [HW-1:0]       ram_waddr, ram_raddr;
  hist_t               ram_wdata, ram_rdata;
  logic [11:0]         vraw;
  logic [LvlW-1:0]     qsat, diff, f;
  logic [VolW-1:0]     vspan;
  logic [SumW+RecipW-1:0] lvl_prod;
  logic [SumW-1:0]        lvl_quo;
  logic [DivW-1:0]        avg_in;
  logic [DivW+AvgSh:0]    avg_prod;
  logic [LvlW-1:0]        avg_quo;

  sbd_div u_div (
    .clk_i, .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  sbd_ram #(.Width($bits(hist_t)), .Depth(HISTORY_FRAMES)) u_hist (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    frm_d = frm_q; idx_d = idx_q; fmin_d = fmin_q; fmax_d = fmax_q;
    vol_d = vol_q; hvol_d = hvol_q; slot_d = slot_q; wrap_d = wrap_q;
    smin_d = smin_q; smax_d = smax_q; amin_d = amin_q; amax_d = amax_q;
    span_d = span_q; vmin_d = vmin_q; vmax_d = vmax_q; scan_d = scan_q;
    rdv_d = 1'b0; vbar_d = vbar_q; ovld_d = ovld_q;
    lvl_d = lvl_q; held_d = held_q; ht_d = ht_q;
    fifo_pop_o = 1'b0;
    div_start = 1'b0; div_num = '0; div_den = 14'd1;
    ram_we = 1'b0; ram_waddr = slot_q; ram_raddr = slot_q;
    ram_wdata = '{vmin: fmin_q, vmax: fmax_q, vol: vol_q};
    vraw  = '0;
    lvl_prod = (SumW+RecipW)'(frm_q.sums[idx_q]) * (SumW+RecipW)'(BAND_RECIP[idx_q]);
    lvl_quo  = lvl_prod[SumW+RecipW-1:RecipSh];
    qsat  = (lvl_quo > SumW'(LevelMax)) ? LevelMax : lvl_quo[LvlW-1:0];
    avg_in   = (idx_q == 3'd0) ? smin_q : smax_q;
    avg_prod = (DivW+AvgSh+1)'(avg_in) * (DivW+AvgSh+1)'(AvgRecip);
    avg_quo  = avg_prod[AvgSh+LvlW-1:AvgSh];
    diff  = (amax_q > amin_q) ? amax_q - amin_q : '0;
    f     = '0;
    vspan = vmax_q - vmin_q;
    cnt   = wrap_q ? (HW+1)'(HISTORY_FRAMES) : {1'b0, slot_q};

    if (pop_i && ovld_q) ovld_d = 1'b0;

    case (state_q)
      B_IDLE: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          frm_d  = frame_i;
          fmin_d = LevelMax;
          fmax_d = '0;
          idx_d  = '0;
          vraw   = (frame_i.raw_vol > 12'(cfg_i.vol_noise)) ?
                   frame_i.raw_vol - 12'(cfg_i.vol_noise) : 12'd0;
          vol_d  = (vraw > 12'(VolumeMax)) ? VolumeMax : vraw[VolW-1:0];
          state_d = B_LVL;
        end
      end
      B_LVL: begin
        lvl_d[idx_q] = qsat;
        if (qsat < fmin_q) fmin_d = qsat;
        if (qsat > fmax_q) fmax_d = qsat;
        if (idx_q == 3'(NumBands - 1)) begin
          idx_d   = '0;
          state_d = frm_q.store ? B_HIST_RD : B_AVG;
        end else begin
          idx_d   = idx_q + 3'd1;
        end
      end
      B_HIST_RD: state_d = B_HIST_UPD;
      B_HIST_UPD: begin
        // unwritten slots read as zero until the history has wrapped once
        smin_d = smin_q - (wrap_q ? DivW'(ram_rdata.vmin) : '0) + DivW'(fmin_q);
        smax_d = smax_q - (wrap_q ? DivW'(ram_rdata.vmax) : '0) + DivW'(fmax_q);
        ram_we = 1'b1;
        if (slot_q == HW'(HISTORY_FRAMES - 1)) begin
          slot_d = '0;
          wrap_d = 1'b1;
        end else begin
          slot_d = slot_q + 1'b1;
        end
        state_d = B_AVG;
      end
      B_AVG: begin
        if (idx_q == 3'd0) begin
          amin_d  = avg_quo;
          idx_d   = 3'd1;
        end else begin
          amax_d  = avg_quo;
          idx_d   = '0;
          state_d = B_SPAN;
        end
      end
      B_SPAN: begin
        if (diff < cfg_i.min_span) span_d = cfg_i.min_span;
        else if (diff > SpanMax) span_d = SpanMax;
        else span_d = diff;
        state_d = B_DEC;
      end
      B_DEC: begin
        held_d[idx_q] = (lvl_q[idx_q] > held_q[idx_q]) ? lvl_q[idx_q] :
                        decayed(held_q[idx_q], cfg_i.decay);
        state_d = B_HT_ST;
      end
      B_HT_ST: begin
        f = held_q[idx_q];
        if (f <= amin_q) begin
          ht_d[idx_q] = '0;
          state_d = B_HT_WT;
        end else if (span_q == '0) begin
          ht_d[idx_q] = (HtMax > 5'd15) ? 4'd15 : HtMax[3:0];
          state_d = B_HT_WT;
        end else begin
          div_start = 1'b1;
          div_num   = DivW'(f - amin_q) * DivW'(Bh);
          div_den   = span_q;
          ht_d[idx_q] = 4'hF;
          state_d = B_HT_WT;
        end
      end
      B_HT_WT: begin
        if (!div_busy) begin
          // a started divide marks the slot; fold in its quotient
          if (ht_q[idx_q] == 4'hF && held_q[idx_q] > amin_q && span_q != '0) begin
            if (div_quo > DivW'(HtMax)) ht_d[idx_q] = (HtMax > 5'd15) ? 4'd15 : HtMax[3:0];
            else ht_d[idx_q] = (div_quo > DivW'(15)) ? 4'd15 : div_quo[3:0];
          end
          if (idx_q == 3'(NumBands - 1)) begin
            idx_d   = '0;
            state_d = B_SCAN_INIT;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = B_DEC;
          end
        end
      end
      B_SCAN_INIT: begin
        vmin_d  = wrap_q ? {VolW{1'b1}} : '0;
        vmax_d  = '0;
        scan_d  = '0;
        state_d = B_SCAN;
      end
      B_SCAN: begin
        ram_raddr = scan_q[HW-1:0];
        if (rdv_q) begin
          if (ram_rdata.vol > vmax_q) vmax_d = ram_rdata.vol;
          if (ram_rdata.vol < vmin_q) vmin_d = ram_rdata.vol;
        end
        if (scan_q < cnt) begin
          rdv_d  = 1'b1;
          scan_d = scan_q + 1'b1;
        end else if (!rdv_q) begin
          state_d = B_VDEC;
        end
      end
      B_VDEC: begin
        if (vol_q < hvol_q) begin
          vol_d  = VolW'(decayed(LvlW'(hvol_q), cfg_i.decay));
          hvol_d = VolW'(decayed(LvlW'(hvol_q), cfg_i.decay));
        end else begin
          hvol_d = vol_q;
        end
        state_d = B_VBAR_ST;
      end
      B_VBAR_ST: begin
        if (vspan != '0 && vol_q > vmin_q) begin
          div_start = 1'b1;
          div_num   = DivW'(vol_q - vmin_q) * DivW'(VbarScale);
          div_den   = 14'(vspan);
          state_d   = B_VBAR_WT;
        end else begin
          vbar_d  = '0;
          state_d = B_OUT;
        end
      end
      B_VBAR_WT: begin
        if (!div_busy) begin
          vbar_d  = (div_quo > DivW'(VbarMax)) ? VbarMax : div_quo[5:0];
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (!ovld_q) begin
          ovld_d  = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      idx_q   <= '0;
      slot_q  <= '0;
      wrap_q  <= 1'b0;
      smin_q  <= '0;
      smax_q  <= '0;
      hvol_q  <= '0;
      rdv_q   <= 1'b0;
      ovld_q  <= 1'b0;
      for (int i = 0; i < NumBands; i++) held_q[i] <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      slot_q  <= slot_d;
      wrap_q  <= wrap_d;
      smin_q  <= smin_d;
      smax_q  <= smax_d;
      hvol_q  <= hvol_d;
      rdv_q   <= rdv_d;
      ovld_q  <= ovld_d;
      held_q  <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frm_q  <= frm_d;
    fmin_q <= fmin_d;
    fmax_q <= fmax_d;
    vol_q  <= vol_d;
    amin_q <= amin_d;
    amax_q <= amax_d;
    span_q <= span_d;
    vmin_q <= vmin_d;
    vmax_q <= vmax_d;
    scan_q <= scan_d;
    vbar_q <= vbar_d;
    lvl_q  <= lvl_d;
    ht_q   <= ht_d;
    if (state_q == B_OUT && !ovld_q) begin
      oht_q   <= ht_q;
      ovbar_q <= vbar_q;
    end
  end

  assign empty_o       = !ovld_q;
  assign height_col0_o = oht_q[0];
  assign height_col1_o = oht_q[1];
  assign height_col2_o = oht_q[2];
  assign height_col3_o = oht_q[3];
  assign height_col4_o = oht_q[4];
  assign volume_bar_o  = ovbar_q;
endmodule

/* tb/sv/spectrum_bar_display_agc_tb.sv */
// Self-checking testbench for the spectrum bar display with automatic gain.
`timescale 1ns / 1ps

module spectrum_bar_display_agc_tb;
  import sbd_pkg::*;

  localparam int Bins       = 32;
  localparam int Frames     = 100;
  localparam int BarH       = 8;
  localparam int StallLimit = 5000;
  localparam int SettleCyc  = 600;

  typedef struct packed {
    logic [NumBands-1:0][3:0] heights;
    logic [5:0]               vbar;
  } bars_t;

  class bar_scoreboard;
    int unsigned vol_noise, min_span, decay;
    int unsigned bin_pos;
    int unsigned band_sum [NumBands];
    int unsigned hist_min [Frames];
    int unsigned hist_max [Frames];
    int unsigned hist_vol [Frames];
    int unsigned wr_slot, min_total, max_total;
    int unsigned held_lvl [NumBands];
    int unsigned held_vol;
    bars_t       pending_bars [$];
    int          errors;

    function new();
      vol_noise = 25; min_span = 300; decay = 238;
      bin_pos = 0; wr_slot = 0; min_total = 0; max_total = 0; held_vol = 0;
      errors = 0;
      foreach (band_sum[i]) band_sum[i] = 0;
      foreach (held_lvl[i]) held_lvl[i] = 0;
      foreach (hist_min[i]) begin
        hist_min[i] = 0; hist_max[i] = 0; hist_vol[i] = 0;
      end
    endfunction

    function void set_reg(cfg_idx_e idx, int unsigned value);
      case (idx)
        REG_VOL_NOISE: vol_noise = value & 10'h3FF;
        REG_MIN_SPAN:  min_span  = value & 14'h3FFF;
        default:       decay     = value & 8'hFF;
      endcase
    endfunction

    function int band_index(int unsigned b);
      if (b == 0) return -1;
      if (b <= 3) return 0;
      if (b <= 6) return 1;
      if (b <= 9) return 2;
      if (b <= 12) return 3;
      return 4;
    endfunction

    function void note_bin(logic [15:0] mag, logic [11:0] rv, bit store, bit last);
      int unsigned nf, val, lvl [NumBands], fmin, fmax, amin, amax, span;
      int unsigned f, h, vmin, vmax, vol, len;
      int          band, v;
      bars_t       r;
      nf = NOISE_TAB[bin_pos];
      val = (mag > nf) ? mag - nf : 0;
      if (val > 10000) val = 10000;
      band = band_index(bin_pos);
      if (band >= 0) begin
        band_sum[band] = band_sum[band] + val;
        if (band_sum[band] > 18'h3FFFF) band_sum[band] = 18'h3FFFF;
      end
      if (!last) begin
        if (bin_pos + 1 < Bins) bin_pos++;
        return;
      end
      fmin = 16383; fmax = 0;
      for (int i = 0; i < NumBands; i++) begin
        lvl[i] = band_sum[i] / BAND_DIV[i];
        if (lvl[i] > 16383) lvl[i] = 16383;
        if (lvl[i] < fmin) fmin = lvl[i];
        if (lvl[i] > fmax) fmax = lvl[i];
      end
      v = int'(rv) - int'(vol_noise);
      if (v < 0) v = 0;
      if (v > 1000) v = 1000;
      vol = unsigned'(v);
      if (store) begin
        min_total = min_total - hist_min[wr_slot] + fmin;
        max_total = max_total - hist_max[wr_slot] + fmax;
        hist_min[wr_slot] = fmin;
        hist_max[wr_slot] = fmax;
        hist_vol[wr_slot] = vol;
        wr_slot = (wr_slot + 1 >= Frames) ? 0 : wr_slot + 1;
      end
      amin = min_total / Frames;
      amax = max_total / Frames;
      span = (amax > amin) ? amax - amin : 0;
      if (span < min_span) span = min_span;
      else if (span > 10000) span = 10000;
      for (int i = 0; i < NumBands; i++) begin
        f = lvl[i];
        h = 0;
        // rise at once, otherwise fall from the held level
        if (f <= held_lvl[i]) f = (held_lvl[i] * decay) >> 8;
        held_lvl[i] = f;
        if (f > amin) begin
          if (span == 0) h = BarH + 1;
          else begin
            h = ((f - amin) * BarH) / span;
            if (h > BarH + 1) h = BarH + 1;
          end
        end
        if (h > 15) h = 15;
        r.heights[i] = 4'(h);
      end
      vmin = 32'hFFFF_FFFF; vmax = 0;
      foreach (hist_vol[i]) begin
        if (hist_vol[i] > vmax) vmax = hist_vol[i];
        if (hist_vol[i] < vmin) vmin = hist_vol[i];
      end
      if (vol < held_vol) vol = (held_vol * decay) >> 8;
      held_vol = vol;
      len = 0;
      if (vmax != vmin && vol > vmin) begin
        len = ((vol - vmin) * 20) / (vmax - vmin);
        if (len > 38) len = 38;
      end
      r.vbar = 6'(len);
      pending_bars.push_back(r);
      foreach (band_sum[i]) band_sum[i] = 0;
      bin_pos = 0;
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_bars(bars_t got);
      bars_t want;
      if (pending_bars.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
        return;
      end
      want = pending_bars.pop_front();
      for (int i = 0; i < NumBands; i++)
        if (got.heights[i] !== want.heights[i])
          report_mismatch($sformatf("height_col%0d", i), got.heights[i], want.heights[i]);
      if (got.vbar !== want.vbar) report_mismatch("volume_bar", got.vbar, want.vbar);
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [15:0] bin_magnitude_i = '0;
  logic [11:0] raw_volume_i = '0;
  logic        store_frame_i = 1'b0;
  logic        last_bin_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  height_col0_o, height_col1_o, height_col2_o, height_col3_o, height_col4_o;
  logic [5:0]  volume_bar_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [13:0] cfg_data_i = '0;

  bar_scoreboard sb = new();
  int unsigned   words_moved = 0;

  spectrum_bar_display_agc #(
    .NUM_BINS(Bins), .HISTORY_FRAMES(Frames), .BAR_HEIGHT(BarH)
  ) DUT (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: outputs are read at the edge before the block updates them.
  int stall_left = 0;
  bit stalling = 1'b0;
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      sb.check_bars({height_col4_o, height_col3_o, height_col2_o, height_col1_o,
                     height_col0_o, volume_bar_o});
      words_moved++;
    end
    if (stall_left == 0) begin
      stalling = ~stalling;
      stall_left = $urandom_range(50, 400);
    end else stall_left--;
    pop <= stalling ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  initial begin : watchdog
    int idle;
    int unsigned seen;
    idle = 0;
    seen = 0;
    forever begin
      @(posedge clk_i);
      if (words_moved != seen) begin
        seen = words_moved;
        idle = 0;
      end else if (++idle >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 14'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, value);
  endtask

  task automatic write_all(int unsigned vn, int unsigned ms, int unsigned dk);
    write_reg(REG_VOL_NOISE, vn);
    write_reg(REG_MIN_SPAN, ms);
    write_reg(REG_DECAY, dk);
  endtask

  // Push one word and hold until the block takes it.
  task automatic send_bin(logic [15:0] mag, logic [11:0] rv, bit store, bit last);
    push            <= 1'b1;
    bin_magnitude_i <= mag;
    raw_volume_i    <= rv;
    store_frame_i   <= store;
    last_bin_i      <= last;
    do @(posedge clk_i); while (full);
    sb.note_bin(mag, rv, store, last);
    words_moved++;
  endtask

  int burst_left = 0;
  task automatic maybe_gap();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 40);
    if ($urandom_range(0, 2) != 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  endtask

  task automatic random_frame(output int sent);
    int          len;
    int          pick;
    bit          store;
    logic [15:0] mag;
    logic [11:0] rv;
    pick = $urandom_range(0, 9);
    if (pick < 5) len = $urandom_range(1, 6);
    else if (pick < 9) len = $urandom_range(7, Bins);
    else len = $urandom_range(Bins + 1, Bins + 8);
    store = ($urandom_range(0, 4) != 0);
    rv = ($urandom_range(0, 1) != 0) ? 12'($urandom) : 12'($urandom_range(0, 1100));
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 3))
        0:       mag = 16'($urandom);
        1:       mag = 16'($urandom_range(0, 200));
        default: mag = 16'($urandom_range(0, 12000));
      endcase
      send_bin(mag, rv, store, i == len - 1);
      maybe_gap();
    end
    sent = len;
  endtask

  // Drop push first so the last word is not taken again.
  task automatic drain();
    push <= 1'b0;
    while (sb.pending_bars.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int sent, n;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero span: equal averages with min span zero light full bars.
    write_all(25, 0, 238);
    for (int i = 0; i < 14; i++) send_bin(16'hFFFF, 12'hFFF, 1'b0, i == 13);
    send_bin(16'h0000, 12'h000, 1'b1, 1'b1);
    send_bin(16'hFFFF, 12'hFFF, 1'b1, 1'b1);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_all(0, 0, 0);
        1: write_all(1023, 10000, 255);
        2: write_all(25, 300, 238);
        default: write_all($urandom_range(0, 1023), $urandom_range(0, 10000),
                           $urandom_range(0, 255));
      endcase
      n = 0;
      while (n < 370) begin
        random_frame(sent);
        n += sent;
      end
      drain();
    end

    if (sb.pending_bars.size() != 0) sb.report_mismatch("words left over", 0, 0);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
